FILE: hw/rtl/i2cram_pkg.sv
// Shared types and constants of the I2C register access master.
`default_nettype none

package i2cram_pkg;

  // Command kinds carried by an input word
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
  localparam logic [1:0] CFG_HALF_PERIOD = 2'd1;

  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned DevAddrW   = 7;
  localparam int unsigned HalfPeriodW = 16;

  localparam logic [DevAddrW-1:0]    DevAddrReset    = 7'd104;
  localparam logic [HalfPeriodW-1:0] HalfPeriodReset = 16'd120;

  // One input word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] reg_num;
    logic [7:0] write_data;
    logic       sda_in;
  } cmd_t;

  // Live configuration seen by the engine
  typedef struct packed {
    logic [DevAddrW-1:0]    dev_addr;
    logic [HalfPeriodW-1:0] half_period;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       nack_seen;
    logic       rejected;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cram_if.sv
// Valid/ready channel interfaces: command, result and configuration.
`default_nettype none

interface i2cram_cmd_if;
  logic                 valid;
  logic                 ready;
  i2cram_pkg::kind_e    kind;
  logic [7:0]           reg_num;
  logic [7:0]           write_data;
  logic                 sda_in;

  modport source (output valid, kind, reg_num, write_data, sda_in, input ready);
  modport sink   (input valid, kind, reg_num, write_data, sda_in, output ready);
endinterface

interface i2cram_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       nack_seen;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_byte, nack_seen, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  read_byte, nack_seen, rejected, output ready);
endinterface

interface i2cram_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [i2cram_pkg::CfgIndexW-1:0]    index;
  logic [i2cram_pkg::CfgDataW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/i2c_register_access_master.sv
// Top level of the I2C register access master: channels, config and pipe registers.
//
//   channel  dir  carries
//   cmd_i    in   kind, reg_num, write_data, sda_in
//   res_o    out  scl_level, sda_level, sda_drive, busy_res, done_res,
//                 read_byte, nack_seen, rejected
//   cfg_i    in   index (0 device_address, 1 half_period_ticks), data
//
// Every word passes through the input register and then the result register. A word
// enters every cycle while the result side is not stalled; the phase sequencer lies
// between the two registers and commits its state as the word moves on.
// Reset returns the bus to idle (SCL high, SDA released) and config to defaults.
// A stalled result holds the pipe; one more word waits in the input register.
`default_nettype none

module i2c_register_access_master #(
  parameter int unsigned TICK_COUNTER_WIDTH = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  i2cram_cmd_if.sink     cmd_i,
  i2cram_res_if.source   res_o,
  i2cram_cfg_if.sink     cfg_i
);
  import i2cram_pkg::*;

  logic                   in_valid_q;
  cmd_t                   in_item_q;
  logic                   out_valid_q;
  res_t                   res_q;
  res_t                   res_d;
  logic [DevAddrW-1:0]    dev_addr_q;
  logic [HalfPeriodW-1:0] half_period_q;
  cfg_t                   cfg;
  logic                   advance;
  logic                   cmd_take;

  // Move the head word into the result register when it is free
  assign advance  = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;
  assign cmd_take = cmd_i.valid && cmd_i.ready;

  assign cfg_i.ready = 1'b1;
  assign cfg.dev_addr    = dev_addr_q;
  assign cfg.half_period = half_period_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DevAddrReset;
      half_period_q <= HalfPeriodReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_DEV_ADDR) dev_addr_q <= cfg_i.data[DevAddrW-1:0];
      if (cfg_i.index == CFG_HALF_PERIOD) half_period_q <= cfg_i.data[HalfPeriodW-1:0];
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      in_item_q.kind       <= cmd_i.kind;
      in_item_q.reg_num    <= cmd_i.reg_num;
      in_item_q.write_data <= cmd_i.write_data;
      in_item_q.sda_in     <= cmd_i.sda_in;
    end
  end

  i2cram_engine #(
    .TickW (TICK_COUNTER_WIDTH)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.scl_level = res_q.scl_level;
  assign res_o.sda_level = res_q.sda_level;
  assign res_o.sda_drive = res_q.sda_drive;
  assign res_o.busy_res  = res_q.busy_res;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.read_byte = res_q.read_byte;
  assign res_o.nack_seen = res_q.nack_seen;
  assign res_o.rejected  = res_q.rejected;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> !res_q.busy_res)
    else $error("transfer done while still busy");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.rejected |-> res_q.busy_res)
    else $error("command rejected while idle");

  a_released_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.sda_drive |-> res_q.sda_level)
    else $error("released data line not reported high");

  a_advance_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced word lost before result register");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/i2cram_engine.sv
// Bus phase sequencer: holds transfer state and computes one result per word.
`default_nettype none

module i2cram_engine #(
  parameter int unsigned TickW = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                step_i,
  input  i2cram_pkg::cmd_t   item_i,
  input  i2cram_pkg::cfg_t   cfg_i,
  output i2cram_pkg::res_t   res_o
);
  import i2cram_pkg::*;

  localparam int unsigned CmpW = (TickW > HalfPeriodW) ? TickW : HalfPeriodW;

  typedef enum logic [3:0] {
    PhIdle, PhStart1, PhStart2, PhTxLow, PhTxHigh, PhAckLow, PhAckHigh, PhRsLow,
    PhRxLow, PhRxHigh, PhNakLow, PhNakHigh, PhStopLow, PhStopHigh, PhStopEnd
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [3:0]       bit_q, bit_d;
  logic [2:0]       byte_q, byte_d;
  logic [7:0]       shift_q, shift_d;
  logic             is_read_q, is_read_d;
  logic [7:0]       held_reg_q, held_reg_d;
  logic [7:0]       held_data_q, held_data_d;
  logic [7:0]       last_read_q, last_read_d;
  logic             nack_q, nack_d;

  // Pick the byte to send for a given position in the transfer
  function automatic logic [7:0] load_byte(input logic [2:0] idx, input logic rd,
                                           input logic [DevAddrW-1:0] dev,
                                           input logic [7:0] rg, input logic [7:0] dat);
    logic [7:0] a;
    a = {dev, 1'b0};
    if (idx == 3'd0) return a;
    else if (idx == 3'd1) return rg;
    else if (rd) return {dev, 1'b1};
    else return dat;
  endfunction

  function automatic logic is_busy(input phase_e ph);
    logic b;
    case (ph)
      PhStart1, PhStart2, PhTxLow, PhTxHigh, PhAckLow, PhAckHigh, PhRsLow, PhRxLow,
      PhRxHigh, PhNakLow, PhNakHigh, PhStopLow, PhStopHigh, PhStopEnd: b = 1'b1;
      default: b = 1'b0;
    endcase
    return b;
  endfunction

  // Next state and result for the word at the head of the pipe
  always_comb begin
    logic                   busy;
    logic                   done;
    logic                   rej;
    logic [HalfPeriodW-1:0] hp;
    logic [TickW-1:0]       nxt;
    logic                   phase_end;
    logic [3:0]             bit_nxt;
    logic [2:0]             byte_nxt;
    logic [7:0]             rx_shift;
    logic                   scl, sdl, drv;

    phase_d     = phase_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    byte_d      = byte_q;
    shift_d     = shift_q;
    is_read_d   = is_read_q;
    held_reg_d  = held_reg_q;
    held_data_d = held_data_q;
    last_read_d = last_read_q;
    nack_d      = nack_q;
    done        = 1'b0;
    rej         = 1'b0;
    busy        = is_busy(phase_q);
    hp          = (cfg_i.half_period == '0) ? HalfPeriodW'(1) : cfg_i.half_period;
    nxt         = tick_q + TickW'(1);
    phase_end   = (CmpW'(nxt) >= CmpW'(hp)) || (tick_q == '1);
    bit_nxt     = bit_q + 4'd1;
    byte_nxt    = byte_q + 3'd1;
    rx_shift    = {shift_q[6:0], item_i.sda_in};

    case (item_i.kind)
      KIND_WRITE, KIND_READ: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          is_read_d   = (item_i.kind == KIND_READ);
          held_reg_d  = item_i.reg_num;
          held_data_d = item_i.write_data;
          nack_d      = 1'b0;
          byte_d      = '0;
          bit_d       = '0;
          shift_d     = '0;
          tick_d      = '0;
          phase_d     = PhStart1;
        end
      end
      KIND_TICK: begin
        if (busy && !phase_end) begin
          tick_d = nxt;
        end else if (busy) begin
          tick_d = '0;
          case (phase_q)
            PhStart1: phase_d = PhStart2;
            PhStart2: begin
              shift_d = load_byte(byte_q, is_read_q, cfg_i.dev_addr, held_reg_q, held_data_q);
              bit_d   = '0;
              phase_d = PhTxLow;
            end
            PhTxLow: phase_d = PhTxHigh;
            PhTxHigh: begin
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_nxt;
              phase_d = (bit_nxt >= 4'd8) ? PhAckLow : PhTxLow;
            end
            PhAckLow: phase_d = PhAckHigh;
            PhAckHigh: begin
              if (item_i.sda_in) nack_d = 1'b1;
              byte_d = byte_nxt;
              if (!is_read_q && byte_nxt >= 3'd3) begin
                phase_d = PhStopLow;
              end else if (is_read_q && byte_nxt == 3'd2) begin
                phase_d = PhRsLow;
              end else if (is_read_q && byte_nxt >= 3'd3) begin
                shift_d = '0;
                bit_d   = '0;
                phase_d = PhRxLow;
              end else begin
                shift_d = load_byte(byte_nxt, is_read_q, cfg_i.dev_addr, held_reg_q,
                                    held_data_q);
                bit_d   = '0;
                phase_d = PhTxLow;
              end
            end
            PhRsLow: phase_d = PhStart1;
            PhRxLow: phase_d = PhRxHigh;
            PhRxHigh: begin
              shift_d = rx_shift;
              bit_d   = bit_nxt;
              if (bit_nxt >= 4'd8) begin
                last_read_d = rx_shift;
                phase_d     = PhNakLow;
              end else begin
                phase_d = PhRxLow;
              end
            end
            PhNakLow:   phase_d = PhNakHigh;
            PhNakHigh:  phase_d = PhStopLow;
            PhStopLow:  phase_d = PhStopHigh;
            PhStopHigh: phase_d = PhStopEnd;
            PhStopEnd: begin
              phase_d = PhIdle;
              done    = 1'b1;
            end
            default: phase_d = PhIdle;
          endcase
        end
      end
      default: ;
    endcase

    // Drive the bus lines from the new phase
    scl = 1'b1;
    sdl = 1'b1;
    drv = 1'b0;
    case (phase_d)
      PhStart1:            begin scl = 1'b1; sdl = 1'b1; drv = 1'b1; end
      PhStart2:            begin scl = 1'b1; sdl = 1'b0; drv = 1'b1; end
      PhTxLow:             begin scl = 1'b0; sdl = shift_d[7]; drv = 1'b1; end
      PhTxHigh:            begin scl = 1'b1; sdl = shift_d[7]; drv = 1'b1; end
      PhAckLow, PhRxLow:   scl = 1'b0;
      PhAckHigh, PhRxHigh: scl = 1'b1;
      PhRsLow, PhNakLow:   begin scl = 1'b0; sdl = 1'b1; drv = 1'b1; end
      PhNakHigh:           begin scl = 1'b1; sdl = 1'b1; drv = 1'b1; end
      PhStopLow:           begin scl = 1'b0; sdl = 1'b0; drv = 1'b1; end
      PhStopHigh:          begin scl = 1'b1; sdl = 1'b0; drv = 1'b1; end
      PhStopEnd:           begin scl = 1'b1; sdl = 1'b1; drv = 1'b1; end
      default: ;
    endcase

    res_o.scl_level = scl;
    res_o.sda_level = drv ? sdl : 1'b1;
    res_o.sda_drive = drv;
    res_o.busy_res  = is_busy(phase_d);
    res_o.done_res  = done;
    res_o.read_byte = last_read_d;
    res_o.nack_seen = nack_d;
    res_o.rejected  = rej;
  end

  // Commit the new state when the word moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      tick_q      <= '0;
      bit_q       <= '0;
      byte_q      <= '0;
      shift_q     <= '0;
      is_read_q   <= 1'b0;
      held_reg_q  <= '0;
      held_data_q <= '0;
      last_read_q <= '0;
      nack_q      <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bit_q       <= bit_d;
      byte_q      <= byte_d;
      shift_q     <= shift_d;
      is_read_q   <= is_read_d;
      held_reg_q  <= held_reg_d;
      held_data_q <= held_data_d;
      last_read_q <= last_read_d;
      nack_q      <= nack_d;
    end
  end

endmodule

`default_nettype wire

FILE: tb/i2cram_result_check.sv
`timescale 1ns / 100ps
// Result checker: tracks the bus sequencer from accepted words and compares every result word.
module i2cram_result_check
  import i2cram_pkg::*;
#(
  parameter int unsigned TickW = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  i2cram_cmd_if  cmd_i,
  i2cram_res_if  res_i,
  i2cram_cfg_if  cfg_i,
  output int     fault_count_o,
  output int     outstanding_o
);

  // Bus phases of the sequencer, in transfer order
  typedef enum logic [4:0] {
    BUS_IDLE      = 5'd0,
    BUS_START_HI  = 5'd1,
    BUS_START_LO  = 5'd2,
    BUS_TX_LOW    = 5'd3,
    BUS_TX_HIGH   = 5'd4,
    BUS_ACK_LOW   = 5'd5,
    BUS_ACK_HIGH  = 5'd6,
    BUS_RS_LOW    = 5'd7,
    BUS_RX_LOW    = 5'd8,
    BUS_RX_HIGH   = 5'd9,
    BUS_NAK_LOW   = 5'd10,
    BUS_NAK_HIGH  = 5'd11,
    BUS_STOP_LOW  = 5'd12,
    BUS_STOP_HIGH = 5'd13,
    BUS_STOP_END  = 5'd14
  } bus_phase_e;

  // Predicted configuration and sequencer state
  logic [DevAddrW-1:0]    dev_addr;
  logic [HalfPeriodW-1:0] half_period;
  bus_phase_e             phase;
  logic [TickW-1:0]       tick_cnt;
  logic [3:0]             bit_idx;
  logic [2:0]             byte_idx;
  logic [7:0]             shift_byte;
  logic                   is_read;
  logic [7:0]             held_reg;
  logic [7:0]             held_data;
  logic [7:0]             last_read;
  logic                   nack_flag;

  res_t expected_words[$];
  int   fault_count = 0;

  assign fault_count_o = fault_count;

  function automatic logic bus_active();
    return (phase >= BUS_START_HI) && (phase <= BUS_STOP_END);
  endfunction

  // Pick the byte to shift out for the current byte slot
  function automatic logic [7:0] slot_byte();
    logic [7:0] addr_w;
    addr_w = {dev_addr, 1'b0};
    if (byte_idx == 3'd0) return addr_w;
    if (byte_idx == 3'd1) return held_reg;
    return is_read ? (addr_w | 8'h01) : held_data;
  endfunction

  // Advance to the next phase; flag the end of STOP
  task automatic close_phase(input logic sda, output logic stop_done);
    stop_done = 1'b0;
    case (phase)
      BUS_START_HI: phase = BUS_START_LO;
      BUS_START_LO: begin
        shift_byte = slot_byte();
        bit_idx    = '0;
        phase      = BUS_TX_LOW;
      end
      BUS_TX_LOW: phase = BUS_TX_HIGH;
      BUS_TX_HIGH: begin
        shift_byte = shift_byte << 1;
        bit_idx    = bit_idx + 4'd1;
        phase      = (bit_idx >= 4'd8) ? BUS_ACK_LOW : BUS_TX_LOW;
      end
      BUS_ACK_LOW: phase = BUS_ACK_HIGH;
      BUS_ACK_HIGH: begin
        if (sda) nack_flag = 1'b1;
        byte_idx = byte_idx + 3'd1;
        if (!is_read && byte_idx >= 3'd3) begin
          phase = BUS_STOP_LOW;
        end else if (is_read && byte_idx == 3'd2) begin
          phase = BUS_RS_LOW;
        end else if (is_read && byte_idx >= 3'd3) begin
          shift_byte = '0;
          bit_idx    = '0;
          phase      = BUS_RX_LOW;
        end else begin
          shift_byte = slot_byte();
          bit_idx    = '0;
          phase      = BUS_TX_LOW;
        end
      end
      BUS_RS_LOW: phase = BUS_START_HI;
      BUS_RX_LOW: phase = BUS_RX_HIGH;
      BUS_RX_HIGH: begin
        shift_byte = {shift_byte[6:0], sda};
        bit_idx    = bit_idx + 4'd1;
        if (bit_idx >= 4'd8) begin
          last_read = shift_byte;
          phase     = BUS_NAK_LOW;
        end else begin
          phase = BUS_RX_LOW;
        end
      end
      BUS_NAK_LOW:   phase = BUS_NAK_HIGH;
      BUS_NAK_HIGH:  phase = BUS_STOP_LOW;
      BUS_STOP_LOW:  phase = BUS_STOP_HIGH;
      BUS_STOP_HIGH: phase = BUS_STOP_END;
      BUS_STOP_END: begin
        phase     = BUS_IDLE;
        stop_done = 1'b1;
      end
      default: phase = BUS_IDLE;
    endcase
  endtask

  // Apply one input word and build the result word it produces
  task automatic predict_word(input kind_e kind, input logic [7:0] reg_a,
                              input logic [7:0] wdata, input logic sda, output res_t r);
    logic                   done;
    logic                   scl;
    logic                   sdl;
    logic                   drv;
    logic [TickW-1:0]       nxt;
    logic [HalfPeriodW-1:0] hp;
    done = 1'b0;
    r    = '0;
    if (kind == KIND_WRITE || kind == KIND_READ) begin
      if (bus_active()) begin
        r.rejected = 1'b1;
      end else begin
        is_read    = (kind == KIND_READ);
        held_reg   = reg_a;
        held_data  = wdata;
        nack_flag  = 1'b0;
        byte_idx   = '0;
        bit_idx    = '0;
        shift_byte = '0;
        tick_cnt   = '0;
        phase      = BUS_START_HI;
      end
    end else if (kind == KIND_TICK && bus_active()) begin
      // a zero half period counts as one tick
      hp  = (half_period == '0) ? HalfPeriodW'(1) : half_period;
      nxt = tick_cnt + 1'b1;
      if (nxt >= hp || tick_cnt == '1) begin
        tick_cnt = '0;
        close_phase(sda, done);
      end else begin
        tick_cnt = nxt;
      end
    end

    // Drive the bus lines for the phase now held
    scl = 1'b1;
    sdl = 1'b1;
    drv = 1'b0;
    case (phase)
      BUS_START_HI:  begin scl = 1'b1; sdl = 1'b1; drv = 1'b1; end
      BUS_START_LO:  begin scl = 1'b1; sdl = 1'b0; drv = 1'b1; end
      BUS_TX_LOW:    begin scl = 1'b0; sdl = shift_byte[7]; drv = 1'b1; end
      BUS_TX_HIGH:   begin scl = 1'b1; sdl = shift_byte[7]; drv = 1'b1; end
      BUS_ACK_LOW, BUS_RX_LOW:   scl = 1'b0;
      BUS_ACK_HIGH, BUS_RX_HIGH: scl = 1'b1;
      BUS_RS_LOW, BUS_NAK_LOW: begin scl = 1'b0; sdl = 1'b1; drv = 1'b1; end
      BUS_NAK_HIGH:  begin scl = 1'b1; sdl = 1'b1; drv = 1'b1; end
      BUS_STOP_LOW:  begin scl = 1'b0; sdl = 1'b0; drv = 1'b1; end
      BUS_STOP_HIGH: begin scl = 1'b1; sdl = 1'b0; drv = 1'b1; end
      BUS_STOP_END:  begin scl = 1'b1; sdl = 1'b1; drv = 1'b1; end
      default: ;
    endcase
    if (!drv) sdl = 1'b1;

    r.scl_level = scl;
    r.sda_level = sdl;
    r.sda_drive = drv;
    r.busy_res  = bus_active();
    r.done_res  = done;
    r.read_byte = last_read;
    r.nack_seen = nack_flag;
  endtask

  task automatic note_fault(input string what, input logic [7:0] want_v, input logic [7:0] got_v);
    fault_count++;
    if (fault_count <= 10)
      $display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  task automatic compare_word(input res_t want, input res_t got);
    if (want.scl_level !== got.scl_level) note_fault("scl_level", want.scl_level, got.scl_level);
    if (want.sda_level !== got.sda_level) note_fault("sda_level", want.sda_level, got.sda_level);
    if (want.sda_drive !== got.sda_drive) note_fault("sda_drive", want.sda_drive, got.sda_drive);
    if (want.busy_res !== got.busy_res) note_fault("busy_res", want.busy_res, got.busy_res);
    if (want.done_res !== got.done_res) note_fault("done_res", want.done_res, got.done_res);
    if (want.read_byte !== got.read_byte) note_fault("read_byte", want.read_byte, got.read_byte);
    if (want.nack_seen !== got.nack_seen) note_fault("nack_seen", want.nack_seen, got.nack_seen);
    if (want.rejected !== got.rejected) note_fault("rejected", want.rejected, got.rejected);
  endtask

  // Track config writes and input words, then match result words in order
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      dev_addr    = DevAddrReset;
      half_period = HalfPeriodReset;
      phase       = BUS_IDLE;
      tick_cnt    = '0;
      bit_idx     = '0;
      byte_idx    = '0;
      shift_byte  = '0;
      is_read     = 1'b0;
      held_reg    = '0;
      held_data   = '0;
      last_read   = '0;
      nack_flag   = 1'b0;
      expected_words.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_DEV_ADDR:    dev_addr = cfg_i.data[DevAddrW-1:0];
          CFG_HALF_PERIOD: half_period = cfg_i.data[HalfPeriodW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready) begin
        predict_word(cmd_i.kind, cmd_i.reg_num, cmd_i.write_data, cmd_i.sda_in, want);
        expected_words.push_back(want);
      end
      if (res_i.valid && res_i.ready) begin
        got.scl_level = res_i.scl_level;
        got.sda_level = res_i.sda_level;
        got.sda_drive = res_i.sda_drive;
        got.busy_res  = res_i.busy_res;
        got.done_res  = res_i.done_res;
        got.read_byte = res_i.read_byte;
        got.nack_seen = res_i.nack_seen;
        got.rejected  = res_i.rejected;
        if (expected_words.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("[%0t] result word with nothing expected: %0h", $time, got);
        end else begin
          want = expected_words.pop_front();
          compare_word(want, got);
        end
      end
      outstanding_o <= expected_words.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives commands, config writes and result stalls, and reports the verdict.
module testbench;
  import i2cram_pkg::*;

  localparam int ClockLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;

  int fault_total;
  int words_outstanding;
  int cycle_count = 0;
  bit steady;
  bit long_hold_req;

  i2cram_cmd_if cmd_ch ();
  i2cram_res_if res_ch ();
  i2cram_cfg_if cfg_ch ();

  i2c_register_access_master #(
    .TICK_COUNTER_WIDTH(16)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  i2cram_result_check #(
    .TickW(16)
  ) result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_ch),
    .res_i         (res_ch),
    .cfg_i         (cfg_ch),
    .fault_count_o (fault_total),
    .outstanding_o (words_outstanding)
  );

  always #2 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == ClockLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one; none while steady is set
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(50, 20);
  endfunction

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    int stall_left;
    hold_left    = 0;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold_left     = 90;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Offer one input word and hold it until accepted
  task automatic put_word(input kind_e k, input logic [7:0] reg_a, input logic [7:0] wdata,
                          input logic sda);
    int gap;
    @(negedge clk_i);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.kind       <= k;
    cmd_ch.reg_num    <= reg_a;
    cmd_ch.write_data <= wdata;
    cmd_ch.sda_in     <= sda;
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic put_ticks(input int n, input int one_pct);
    repeat (n) put_word(KIND_TICK, 8'($urandom), 8'($urandom), $urandom_range(99) < one_pct);
  endtask

  // Mostly ticks, with commands and the unused kind mixed in
  task automatic put_random(input int one_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3)
      put_word(KIND_WRITE, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
    else if (r < 6)
      put_word(KIND_READ, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
    else if (r < 7)
      put_word(kind_e'(2'd3), 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
    else
      put_word(KIND_TICK, 8'($urandom), 8'($urandom), $urandom_range(99) < one_pct);
  endtask

  // Stop offering and wait until every result word is back
  task automatic drain();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (words_outstanding != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [6:0] addr, input logic [15:0] hp, input int n,
                           input int one_pct);
    write_reg(CFG_DEV_ADDR, {9'd0, addr});
    write_reg(CFG_HALF_PERIOD, hp);
    repeat (n) put_random(one_pct);
  endtask

  initial begin
    rst_ni             = 1'b0;
    steady             = 1'b0;
    long_hold_req      = 1'b0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.kind        = KIND_TICK;
    cmd_ch.reg_num     = '0;
    cmd_ch.write_data  = '0;
    cmd_ch.sda_in      = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_DEV_ADDR;
    cfg_ch.data        = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Idle bus: unused kind and plain ticks change nothing
    put_word(kind_e'(2'd3), 8'hFF, 8'hFF, 1'b1);
    put_word(KIND_TICK, 8'h00, 8'h00, 1'b0);
    put_word(KIND_TICK, 8'hFF, 8'hFF, 1'b1);
    // Start a write at reset config, then try commands while busy
    put_word(KIND_WRITE, 8'hFF, 8'h00, 1'b0);
    put_word(KIND_READ, 8'h12, 8'h34, 1'b1);
    put_word(KIND_WRITE, 8'h00, 8'hFF, 1'b0);
    put_word(kind_e'(2'd3), 8'h00, 8'h00, 1'b0);
    put_ticks(130, 0);

    // Zero half period acts as one; widest address
    write_reg(CFG_HALF_PERIOD, 16'd0);
    write_reg(CFG_DEV_ADDR, 16'hFFFF);
    put_ticks(80, 0);
    // Read with the line left high: every slot unacknowledged, byte of all ones
    put_word(KIND_READ, 8'h00, 8'hFF, 1'b1);
    put_ticks(100, 100);

    write_reg(CFG_DEV_ADDR, 16'd0);
    write_reg(CFG_HALF_PERIOD, 16'd1);
    put_word(KIND_WRITE, 8'h5A, 8'hA5, 1'b0);
    put_ticks(70, 0);
    put_word(KIND_READ, 8'hA5, 8'h5A, 1'b0);
    put_ticks(100, 50);

    // Longest half period: start a transfer, then shorten the phases mid-flight
    write_reg(CFG_HALF_PERIOD, 16'hFFFF);
    put_word(KIND_WRITE, 8'h3C, 8'hC3, 1'b0);
    put_ticks(40, 50);
    write_reg(CFG_HALF_PERIOD, 16'd2);
    put_ticks(120, 20);

    // Random phase with a long result hold-off and a full sender pause
    write_reg(CFG_DEV_ADDR, 16'($urandom_range(127)));
    write_reg(CFG_HALF_PERIOD, 16'd1);
    repeat (80) put_random(50);
    steady        = 1'b1;
    long_hold_req = 1'b1;
    repeat (60) put_random(50);
    steady = 1'b0;
    repeat (40) put_random(50);
    drain();
    repeat (70) put_random(50);

    steady = 1'b1;
    run_phase(7'h55, 16'd2, 60, 10);
    steady = 1'b0;
    run_phase(7'($urandom_range(127)), 16'd0, 60, 90);
    run_phase(7'h2A, 16'd3, 60, 30);

    drain();
    if (fault_total == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
